/* hw/rtl/sbc_pkg.sv */
package sbc_pkg;

   // quotient lanes of the time divider
   localparam int DIV_LANES = 4;
   localparam int LANE_XS   = 0;
   localparam int LANE_XE   = 1;
   localparam int LANE_YS   = 2;
   localparam int LANE_YE   = 3;

   // time magnitudes saturate at 2^62-1 time units
   localparam int TIME_CAP_BITS = 62;

   // per-request axis usage and overlap flags
   typedef struct packed {
      logic use_x;
      logic use_y;
      logic meet_x;
      logic meet_y;
   } sbc_axis_type;

   // per-request outcome flags
   typedef struct packed {
      logic hit;
      logic slide_x;
      logic slide_y;
   } sbc_hit_type;

endpackage

/* hw/rtl/sbc_div_pipe.sv */
module sbc_div_pipe #(
   parameter int COORD_BITS     = 24,
   parameter int TIME_FRAC_BITS = 16,
   parameter int SIDE_BITS      = 52
) (
   input  logic                                                       clock,
   input  logic                                                       reset,
   input  logic                                                       in_valid,
   output logic                                                       in_ready,
   input  logic [sbc_pkg::DIV_LANES-1:0][COORD_BITS-1:0]              in_num,
   input  logic [sbc_pkg::DIV_LANES-1:0][COORD_BITS-1:0]              in_den,
   input  logic [sbc_pkg::DIV_LANES-1:0]                              in_neg,
   input  logic [SIDE_BITS-1:0]                                       in_side,
   output logic                                                       out_valid,
   input  logic                                                       out_ready,
   output logic [sbc_pkg::DIV_LANES-1:0][COORD_BITS+TIME_FRAC_BITS-1:0] out_quo,
   output logic [sbc_pkg::DIV_LANES-1:0]                              out_neg,
   output logic [SIDE_BITS-1:0]                                       out_side
);

   localparam int C     = COORD_BITS;
   localparam int QW    = COORD_BITS + TIME_FRAC_BITS;
   localparam int NSTG  = QW + 1;
   localparam int LANES = sbc_pkg::DIV_LANES;

   logic [LANES-1:0][C-1:0]  rem_ff  [NSTG];
   logic [LANES-1:0][C-1:0]  rem_in  [NSTG];
   logic [LANES-1:0][QW-1:0] dq_ff   [NSTG];
   logic [LANES-1:0][QW-1:0] dq_in   [NSTG];
   logic [LANES-1:0][C-1:0]  den_ff  [NSTG];
   logic [LANES-1:0]         neg_ff  [NSTG];
   logic [SIDE_BITS-1:0]     side_ff [NSTG];
   logic                     v_ff    [NSTG];
   logic                     adv     [NSTG+1];

   assign adv[NSTG] = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[NSTG-1];
   assign out_quo   = dq_ff[NSTG-1];
   assign out_neg   = neg_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

   // load stage: dividend is the gap magnitude scaled by the time fraction
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem_in[0][l] = '0;
         dq_in[0][l]  = {in_num[l], {TIME_FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0]  <= rem_in[0];
         dq_ff[0]   <= dq_in[0];
         den_ff[0]  <= in_den;
         neg_ff[0]  <= in_neg;
         side_ff[0] <= in_side;
      end
   end

   assign adv[0] = !v_ff[0] || adv[1];

   // one restoring quotient bit per stage
   for (genvar s = 1; s < NSTG; s++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [C-1:0] trial;
         logic         ge;
         always_comb begin
            trial         = {rem_ff[s-1][l][C-2:0], dq_ff[s-1][l][QW-1]};
            ge            = trial >= den_ff[s-1][l];
            rem_in[s][l]  = ge ? trial - den_ff[s-1][l] : trial;
            dq_in[s][l]   = {dq_ff[s-1][l][QW-2:0], ge};
         end
      end

      assign adv[s] = !v_ff[s] || adv[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in[s];
            dq_ff[s]   <= dq_in[s];
            den_ff[s]  <= den_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

endmodule

/* hw/rtl/sbc_resolve.sv */
module sbc_resolve #(
   parameter int COORD_BITS     = 24,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                                                       clock,
   input  logic                                                       reset,
   input  logic                                                       in_valid,
   output logic                                                       in_ready,
   input  logic [sbc_pkg::DIV_LANES-1:0][COORD_BITS+TIME_FRAC_BITS-1:0] in_quo,
   input  logic [sbc_pkg::DIV_LANES-1:0]                              in_neg,
   input  sbc_pkg::sbc_axis_type                                      in_axis,
   input  logic signed [COORD_BITS-1:0]                               in_vx,
   input  logic signed [COORD_BITS-1:0]                               in_vy,
   output logic                                                       out_valid,
   input  logic                                                       out_ready,
   output sbc_pkg::sbc_hit_type                                       out_flags,
   output logic signed [COORD_BITS-1:0]                               out_ax,
   output logic signed [COORD_BITS-1:0]                               out_ay,
   output logic signed [COORD_BITS:0]                                 out_slide_x,
   output logic signed [COORD_BITS:0]                                 out_slide_y,
   output logic [2*COORD_BITS-1:0]                                    out_sum
);

   localparam int C     = COORD_BITS;
   localparam int F     = TIME_FRAC_BITS;
   localparam int QW    = C + F;
   localparam int TW    = QW + 1;
   localparam int L     = C / 2;
   localparam int H     = C - L;
   localparam int NSTG  = 7;
   localparam int LANES = sbc_pkg::DIV_LANES;
   localparam int CAP_SHIFT = (QW > sbc_pkg::TIME_CAP_BITS) ? QW - sbc_pkg::TIME_CAP_BITS : 0;
   localparam logic [QW-1:0] TIME_CAP = {QW{1'b1}} >> CAP_SHIFT;
   localparam logic signed [TW-1:0] TIME_ONE = {{(TW-1){1'b0}}, 1'b1} << F;

   logic v_ff [NSTG];
   logic adv  [NSTG+1];

   // stage 0: signed, saturated times
   logic signed [TW-1:0]  t0_time_ff [LANES];
   logic signed [TW-1:0]  t0_time_in [LANES];
   sbc_pkg::sbc_axis_type t0_axis_ff;
   logic signed [C-1:0]   t0_vx_ff, t0_vy_ff;

   // stage 1: hit decision and clamped entry time
   sbc_pkg::sbc_hit_type  d1_flags_ff, d1_flags_in;
   logic [F-1:0]          d1_st_ff, d1_st_in;
   logic signed [C-1:0]   d1_vx_ff, d1_vy_ff;

   // stage 2: partial products of motion times entry time
   logic [L+F-1:0]        m2_plo_x_ff, m2_plo_x_in, m2_plo_y_ff, m2_plo_y_in;
   logic [H+F-1:0]        m2_phi_x_ff, m2_phi_x_in, m2_phi_y_ff, m2_phi_y_in;
   sbc_pkg::sbc_hit_type  m2_flags_ff;
   logic signed [C-1:0]   m2_vx_ff, m2_vy_ff;

   // stage 3: allowed move
   logic signed [C-1:0]   a3_ax_ff, a3_ax_in, a3_ay_ff, a3_ay_in;
   logic signed [C-1:0]   a3_vx_ff, a3_vy_ff;
   sbc_pkg::sbc_hit_type  a3_flags_ff;

   // stage 4: square partial products and slide
   logic [2*H-1:0]        q4_hh_x_ff, q4_hh_x_in, q4_hh_y_ff, q4_hh_y_in;
   logic [C-1:0]          q4_hl_x_ff, q4_hl_x_in, q4_hl_y_ff, q4_hl_y_in;
   logic [2*L-1:0]        q4_ll_x_ff, q4_ll_x_in, q4_ll_y_ff, q4_ll_y_in;
   logic signed [C:0]     q4_sx_ff, q4_sx_in, q4_sy_ff, q4_sy_in;
   logic signed [C-1:0]   q4_ax_ff, q4_ay_ff;
   sbc_pkg::sbc_hit_type  q4_flags_ff;

   // stage 5: per-axis squares
   logic [2*C-1:0]        s5_sq_x_ff, s5_sq_x_in, s5_sq_y_ff, s5_sq_y_in;
   logic signed [C:0]     s5_sx_ff, s5_sy_ff;
   logic signed [C-1:0]   s5_ax_ff, s5_ay_ff;
   sbc_pkg::sbc_hit_type  s5_flags_ff;

   // stage 6: sum of squares
   logic [2*C-1:0]        s6_sum_ff;
   logic signed [C:0]     s6_sx_ff, s6_sy_ff;
   logic signed [C-1:0]   s6_ax_ff, s6_ay_ff;
   sbc_pkg::sbc_hit_type  s6_flags_ff;

   // valid chain with per-stage bubble collapse
   assign adv[NSTG] = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[NSTG-1];

   for (genvar k = 0; k < NSTG; k++) begin : g_valid
      assign adv[k] = !v_ff[k] || adv[k+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // saturate and sign the quotients
   always_comb begin
      logic [QW-1:0] qc;
      logic [TW-1:0] ext;
      for (int l = 0; l < LANES; l++) begin
         qc            = (in_quo[l] > TIME_CAP) ? TIME_CAP : in_quo[l];
         ext           = {1'b0, qc};
         t0_time_in[l] = in_neg[l] ? $signed(-ext) : $signed(ext);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t0_time_ff <= t0_time_in;
         t0_axis_ff <= in_axis;
         t0_vx_ff   <= in_vx;
         t0_vy_ff   <= in_vy;
      end
   end

   // pick entry and exit times, decide the hit
   always_comb begin
      logic signed [TW-1:0] xs, xe, ys, ye, start_t, stop_t;
      logic ux, uy;
      xs = t0_time_ff[sbc_pkg::LANE_XS];
      xe = t0_time_ff[sbc_pkg::LANE_XE];
      ys = t0_time_ff[sbc_pkg::LANE_YS];
      ye = t0_time_ff[sbc_pkg::LANE_YE];
      ux = t0_axis_ff.use_x;
      uy = t0_axis_ff.use_y;
      start_t = TIME_ONE;
      stop_t  = '0;
      d1_flags_in.slide_x = 1'b1;
      d1_flags_in.slide_y = 1'b1;
      if (ux && uy) begin
         start_t = (xs > ys) ? xs : ys;
         stop_t  = (xe < ye) ? xe : ye;
      end else if (ux && t0_axis_ff.meet_y) begin
         start_t = xs;
         stop_t  = xe;
         d1_flags_in.slide_y = 1'b0;
      end else if (uy && t0_axis_ff.meet_x) begin
         start_t = ys;
         stop_t  = ye;
         d1_flags_in.slide_x = 1'b0;
      end
      if (ux && start_t == xs) begin
         d1_flags_in.slide_x = 1'b0;
      end
      if (uy && start_t == ys) begin
         d1_flags_in.slide_y = 1'b0;
      end
      d1_flags_in.hit = !(stop_t <= start_t || start_t >= TIME_ONE || stop_t <= 0);
      d1_st_in = start_t[TW-1] ? '0 : start_t[F-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d1_flags_ff <= d1_flags_in;
         d1_st_ff    <= d1_st_in;
         d1_vx_ff    <= t0_vx_ff;
         d1_vy_ff    <= t0_vy_ff;
      end
   end

   // split multiply of motion magnitude by entry time
   always_comb begin
      logic [C-1:0] mvx, mvy;
      mvx = d1_vx_ff[C-1] ? $unsigned(-d1_vx_ff) : $unsigned(d1_vx_ff);
      mvy = d1_vy_ff[C-1] ? $unsigned(-d1_vy_ff) : $unsigned(d1_vy_ff);
      m2_plo_x_in = mvx[L-1:0] * d1_st_ff;
      m2_phi_x_in = mvx[C-1:L] * d1_st_ff;
      m2_plo_y_in = mvy[L-1:0] * d1_st_ff;
      m2_phi_y_in = mvy[C-1:L] * d1_st_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         m2_plo_x_ff <= m2_plo_x_in;
         m2_phi_x_ff <= m2_phi_x_in;
         m2_plo_y_ff <= m2_plo_y_in;
         m2_phi_y_ff <= m2_phi_y_in;
         m2_flags_ff <= d1_flags_ff;
         m2_vx_ff    <= d1_vx_ff;
         m2_vy_ff    <= d1_vy_ff;
      end
   end

   // combine partial products, truncate, restore sign
   always_comb begin
      logic [C+F-1:0] px, py;
      logic [C-1:0]   amx, amy;
      px  = {m2_phi_x_ff, {L{1'b0}}} + {{H{1'b0}}, m2_plo_x_ff};
      py  = {m2_phi_y_ff, {L{1'b0}}} + {{H{1'b0}}, m2_plo_y_ff};
      amx = px[C+F-1:F];
      amy = py[C+F-1:F];
      a3_ax_in = m2_vx_ff[C-1] ? $signed(-amx) : $signed(amx);
      a3_ay_in = m2_vy_ff[C-1] ? $signed(-amy) : $signed(amy);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         a3_ax_ff    <= a3_ax_in;
         a3_ay_ff    <= a3_ay_in;
         a3_vx_ff    <= m2_vx_ff;
         a3_vy_ff    <= m2_vy_ff;
         a3_flags_ff <= m2_flags_ff;
      end
   end

   // leftover motion and split squares of the allowed move
   always_comb begin
      logic [C-1:0] amx, amy;
      q4_sx_in = $signed({a3_vx_ff[C-1], a3_vx_ff}) - $signed({a3_ax_ff[C-1], a3_ax_ff});
      q4_sy_in = $signed({a3_vy_ff[C-1], a3_vy_ff}) - $signed({a3_ay_ff[C-1], a3_ay_ff});
      amx = a3_ax_ff[C-1] ? $unsigned(-a3_ax_ff) : $unsigned(a3_ax_ff);
      amy = a3_ay_ff[C-1] ? $unsigned(-a3_ay_ff) : $unsigned(a3_ay_ff);
      q4_hh_x_in = amx[C-1:L] * amx[C-1:L];
      q4_hl_x_in = amx[C-1:L] * amx[L-1:0];
      q4_ll_x_in = amx[L-1:0] * amx[L-1:0];
      q4_hh_y_in = amy[C-1:L] * amy[C-1:L];
      q4_hl_y_in = amy[C-1:L] * amy[L-1:0];
      q4_ll_y_in = amy[L-1:0] * amy[L-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         q4_hh_x_ff  <= q4_hh_x_in;
         q4_hl_x_ff  <= q4_hl_x_in;
         q4_ll_x_ff  <= q4_ll_x_in;
         q4_hh_y_ff  <= q4_hh_y_in;
         q4_hl_y_ff  <= q4_hl_y_in;
         q4_ll_y_ff  <= q4_ll_y_in;
         q4_sx_ff    <= q4_sx_in;
         q4_sy_ff    <= q4_sy_in;
         q4_ax_ff    <= a3_ax_ff;
         q4_ay_ff    <= a3_ay_ff;
         q4_flags_ff <= a3_flags_ff;
      end
   end

   // assemble per-axis squares
   always_comb begin
      s5_sq_x_in = {q4_hh_x_ff, {(2*L){1'b0}}}
                 + {{(H-1){1'b0}}, q4_hl_x_ff, {(L+1){1'b0}}}
                 + {{(2*H){1'b0}}, q4_ll_x_ff};
      s5_sq_y_in = {q4_hh_y_ff, {(2*L){1'b0}}}
                 + {{(H-1){1'b0}}, q4_hl_y_ff, {(L+1){1'b0}}}
                 + {{(2*H){1'b0}}, q4_ll_y_ff};
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_sq_x_ff  <= s5_sq_x_in;
         s5_sq_y_ff  <= s5_sq_y_in;
         s5_sx_ff    <= q4_sx_ff;
         s5_sy_ff    <= q4_sy_ff;
         s5_ax_ff    <= q4_ax_ff;
         s5_ay_ff    <= q4_ay_ff;
         s5_flags_ff <= q4_flags_ff;
      end
   end

   // squared length
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_sum_ff   <= s5_sq_x_ff + s5_sq_y_ff;
         s6_sx_ff    <= s5_sx_ff;
         s6_sy_ff    <= s5_sy_ff;
         s6_ax_ff    <= s5_ax_ff;
         s6_ay_ff    <= s5_ay_ff;
         s6_flags_ff <= s5_flags_ff;
      end
   end

   assign out_flags   = s6_flags_ff;
   assign out_ax      = s6_ax_ff;
   assign out_ay      = s6_ay_ff;
   assign out_slide_x = s6_sx_ff;
   assign out_slide_y = s6_sy_ff;
   assign out_sum     = s6_sum_ff;

endmodule

/* hw/rtl/sbc_sqrt_pipe.sv */
module sbc_sqrt_pipe #(
   parameter int COORD_BITS = 24,
   parameter int SIDE_BITS  = 101
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2*COORD_BITS-1:0] in_sum,
   input  logic [SIDE_BITS-1:0]    in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [COORD_BITS-1:0]   out_root,
   output logic [SIDE_BITS-1:0]    out_side
);

   localparam int C    = COORD_BITS;
   localparam int NSTG = C + 1;

   logic [2*C-1:0]       rem_ff  [NSTG];
   logic [2*C-1:0]       rem_in  [NSTG];
   logic [C-1:0]         root_ff [NSTG];
   logic [C-1:0]         root_in [NSTG];
   logic [SIDE_BITS-1:0] side_ff [NSTG];
   logic                 v_ff    [NSTG];
   logic                 adv     [NSTG+1];

   assign adv[NSTG] = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[NSTG-1];
   assign out_root  = root_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

   // load stage
   assign rem_in[0]  = in_sum;
   assign root_in[0] = '0;
   assign adv[0]     = !v_ff[0] || adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0]  <= rem_in[0];
         root_ff[0] <= root_in[0];
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage, most significant first
   for (genvar s = 1; s < NSTG; s++) begin : g_step
      localparam int B = C - s;
      logic [2*C:0] trial;
      logic         ge;

      always_comb begin
         trial = ({{(C+1){1'b0}}, root_ff[s-1]} << (B + 1))
               | ({{(2*C){1'b0}}, 1'b1} << (2 * B));
         ge    = {1'b0, rem_ff[s-1]} >= trial;
         rem_in[s]  = ge ? rem_ff[s-1] - trial[2*C-1:0] : rem_ff[s-1];
         root_in[s] = ge ? (root_ff[s-1] | ({{(C-1){1'b0}}, 1'b1} << B)) : root_ff[s-1];
      end

      assign adv[s] = !v_ff[s] || adv[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

endmodule

/* hw/rtl/swept_box_collision_unit.sv */
// swept box collision unit
// one moving box with a motion vector is tested against one fixed box per
// request. all coordinates and motions are signed fixed point with 8
// fraction bits, COORD_BITS wide.
// request channel: req_valid/req_ready with ten coordinate fields.
// response channel: rsp_valid/rsp_ready with hit, allowed move, contact
// length, slide vector and corner flag; every field is zero without a hit.
// throughput: one request per cycle, sustained while rsp_ready stays high.
// pipeline: the bit-per-stage time divider (COORD_BITS + TIME_FRAC_BITS + 1
// stages), seven resolve and multiply stages, and the bit-per-stage square
// root (COORD_BITS + 1 stages).
// each stage holds its request until the next stage frees up, so a stalled
// receiver only backs up the pipeline as far as it is full; empty stages
// keep taking new requests meanwhile.
// reset is synchronous and empties the pipeline; nothing is lost or
// repeated across a stall.
module swept_box_collision_unit #(
   parameter int COORD_BITS     = 24,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_mover_left,
   input  logic signed [COORD_BITS-1:0] req_mover_top,
   input  logic signed [COORD_BITS-1:0] req_mover_right,
   input  logic signed [COORD_BITS-1:0] req_mover_bottom,
   input  logic signed [COORD_BITS-1:0] req_target_left,
   input  logic signed [COORD_BITS-1:0] req_target_top,
   input  logic signed [COORD_BITS-1:0] req_target_right,
   input  logic signed [COORD_BITS-1:0] req_target_bottom,
   input  logic signed [COORD_BITS-1:0] req_motion_x,
   input  logic signed [COORD_BITS-1:0] req_motion_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic signed [COORD_BITS-1:0] rsp_allowed_x,
   output logic signed [COORD_BITS-1:0] rsp_allowed_y,
   output logic [COORD_BITS-1:0]        rsp_contact_length,
   output logic signed [COORD_BITS:0]   rsp_slide_x,
   output logic signed [COORD_BITS:0]   rsp_slide_y,
   output logic                         rsp_corner_hit
);

   localparam int C     = COORD_BITS;
   localparam int QW    = COORD_BITS + TIME_FRAC_BITS;
   localparam int LANES = sbc_pkg::DIV_LANES;
   localparam int AXW   = $bits(sbc_pkg::sbc_axis_type);
   localparam int HFW   = $bits(sbc_pkg::sbc_hit_type);
   localparam int DSW   = AXW + 2 * C;
   localparam int RSW   = HFW + 4 * C + 2;

   // open-interval test of the original overlap check
   function automatic logic within_span(input logic signed [C-1:0] v,
                                        input logic signed [C-1:0] p,
                                        input logic signed [C-1:0] q);
      logic signed [C-1:0] lo, hi;
      lo = (p < q) ? p : q;
      hi = (p > q) ? p : q;
      return (v > lo) && (v < hi);
   endfunction

   function automatic logic spans_meet(input logic signed [C-1:0] a1,
                                       input logic signed [C-1:0] a2,
                                       input logic signed [C-1:0] b1,
                                       input logic signed [C-1:0] b2);
      logic signed [C-1:0] alo, ahi, blo, bhi;
      alo = (a1 < a2) ? a1 : a2;
      ahi = (a1 > a2) ? a1 : a2;
      blo = (b1 < b2) ? b1 : b2;
      bhi = (b1 > b2) ? b1 : b2;
      return within_span(a1, b1, b2) || within_span(a2, b1, b2) ||
             within_span(b1, a1, a2) || (alo == blo) || (ahi == bhi);
   endfunction

   function automatic logic [C-1:0] abs_gap(input logic signed [C:0] v);
      logic [C:0] a;
      a = v[C] ? $unsigned(-v) : $unsigned(v);
      return a[C-1:0];
   endfunction

   function automatic logic [C-1:0] abs_coord(input logic signed [C-1:0] v);
      return v[C-1] ? $unsigned(-v) : $unsigned(v);
   endfunction

   logic signed [C:0]         gx_a, gx_b, gy_a, gy_b;
   logic signed [C:0]         num_xs, num_xe, num_ys, num_ye;
   logic                      pos_x, pos_y;
   sbc_pkg::sbc_axis_type     axis;
   logic [LANES-1:0][C-1:0]   div_num, div_den;
   logic [LANES-1:0]          div_neg;
   logic [DSW-1:0]            div_side, dq_side;
   logic                      dq_valid, dq_ready;
   logic [LANES-1:0][QW-1:0]  dq_quo;
   logic [LANES-1:0]          dq_neg;
   sbc_pkg::sbc_axis_type     dq_axis;
   logic signed [C-1:0]       dq_vx, dq_vy;

   logic                      rs_valid, rs_ready;
   sbc_pkg::sbc_hit_type      rs_flags;
   logic signed [C-1:0]       rs_ax, rs_ay;
   logic signed [C:0]         rs_sx, rs_sy;
   logic [2*C-1:0]            rs_sum;

   logic [RSW-1:0]            sq_side;
   logic [C-1:0]              sq_root;
   sbc_pkg::sbc_hit_type      sq_flags;
   logic signed [C-1:0]       sq_ax, sq_ay;
   logic signed [C:0]         sq_sx, sq_sy;

   // gaps, numerator selection by motion direction, overlap flags
   always_comb begin
      gx_a  = $signed({req_target_left[C-1], req_target_left})
            - $signed({req_mover_right[C-1], req_mover_right});
      gx_b  = $signed({req_target_right[C-1], req_target_right})
            - $signed({req_mover_left[C-1], req_mover_left});
      gy_a  = $signed({req_target_top[C-1], req_target_top})
            - $signed({req_mover_bottom[C-1], req_mover_bottom});
      gy_b  = $signed({req_target_bottom[C-1], req_target_bottom})
            - $signed({req_mover_top[C-1], req_mover_top});
      pos_x = !req_motion_x[C-1] && (req_motion_x != '0);
      pos_y = !req_motion_y[C-1] && (req_motion_y != '0);
      num_xs = pos_x ? gx_a : gx_b;
      num_xe = pos_x ? gx_b : gx_a;
      num_ys = pos_y ? gy_a : gy_b;
      num_ye = pos_y ? gy_b : gy_a;

      div_num[sbc_pkg::LANE_XS] = abs_gap(num_xs);
      div_num[sbc_pkg::LANE_XE] = abs_gap(num_xe);
      div_num[sbc_pkg::LANE_YS] = abs_gap(num_ys);
      div_num[sbc_pkg::LANE_YE] = abs_gap(num_ye);
      div_den[sbc_pkg::LANE_XS] = abs_coord(req_motion_x);
      div_den[sbc_pkg::LANE_XE] = abs_coord(req_motion_x);
      div_den[sbc_pkg::LANE_YS] = abs_coord(req_motion_y);
      div_den[sbc_pkg::LANE_YE] = abs_coord(req_motion_y);
      div_neg[sbc_pkg::LANE_XS] = num_xs[C] ^ req_motion_x[C-1];
      div_neg[sbc_pkg::LANE_XE] = num_xe[C] ^ req_motion_x[C-1];
      div_neg[sbc_pkg::LANE_YS] = num_ys[C] ^ req_motion_y[C-1];
      div_neg[sbc_pkg::LANE_YE] = num_ye[C] ^ req_motion_y[C-1];

      axis.use_x  = req_motion_x != '0;
      axis.use_y  = req_motion_y != '0;
      axis.meet_x = spans_meet(req_mover_left, req_mover_right,
                               req_target_left, req_target_right);
      axis.meet_y = spans_meet(req_mover_top, req_mover_bottom,
                               req_target_top, req_target_bottom);
      div_side = {axis, req_motion_x, req_motion_y};
   end

   // entry and exit times
   sbc_div_pipe #(
      .COORD_BITS     (COORD_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS),
      .SIDE_BITS      (DSW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_neg    (div_neg),
      .in_side   (div_side),
      .out_valid (dq_valid),
      .out_ready (dq_ready),
      .out_quo   (dq_quo),
      .out_neg   (dq_neg),
      .out_side  (dq_side)
   );

   assign {dq_axis, dq_vx, dq_vy} = dq_side;

   // hit decision, allowed move, squared length
   sbc_resolve #(
      .COORD_BITS     (COORD_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_resolve (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dq_valid),
      .in_ready    (dq_ready),
      .in_quo      (dq_quo),
      .in_neg      (dq_neg),
      .in_axis     (dq_axis),
      .in_vx       (dq_vx),
      .in_vy       (dq_vy),
      .out_valid   (rs_valid),
      .out_ready   (rs_ready),
      .out_flags   (rs_flags),
      .out_ax      (rs_ax),
      .out_ay      (rs_ay),
      .out_slide_x (rs_sx),
      .out_slide_y (rs_sy),
      .out_sum     (rs_sum)
   );

   // contact length
   sbc_sqrt_pipe #(
      .COORD_BITS (COORD_BITS),
      .SIDE_BITS  (RSW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rs_valid),
      .in_ready  (rs_ready),
      .in_sum    (rs_sum),
      .in_side   ({rs_flags, rs_ax, rs_ay, rs_sx, rs_sy}),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_flags, sq_ax, sq_ay, sq_sx, sq_sy} = sq_side;

   // zero every field when there is no hit
   assign rsp_hit            = sq_flags.hit;
   assign rsp_allowed_x      = sq_flags.hit ? sq_ax : '0;
   assign rsp_allowed_y      = sq_flags.hit ? sq_ay : '0;
   assign rsp_contact_length = sq_flags.hit ? sq_root : '0;
   assign rsp_slide_x        = (sq_flags.hit && sq_flags.slide_x) ? sq_sx : '0;
   assign rsp_slide_y        = (sq_flags.hit && sq_flags.slide_y) ? sq_sy : '0;
   assign rsp_corner_hit     = sq_flags.hit && !sq_flags.slide_x && !sq_flags.slide_y;

endmodule

/* hw/rtl/sbc_checker.sv */
module sbc_checker #(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic signed [COORD_BITS-1:0] rsp_allowed_x,
   input logic signed [COORD_BITS-1:0] rsp_allowed_y,
   input logic [COORD_BITS-1:0]        rsp_contact_length,
   input logic signed [COORD_BITS:0]   rsp_slide_x,
   input logic signed [COORD_BITS:0]   rsp_slide_y,
   input logic                         rsp_corner_hit
);

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response keeps its valid, hit, allowed move and contact length
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_allowed_x) && $stable(rsp_allowed_y) && $stable(rsp_contact_length))
      else $error("stalled response changed");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_allowed_x == '0 && rsp_allowed_y == '0 &&
      rsp_contact_length == '0 && rsp_slide_x == '0 && rsp_slide_y == '0 &&
      !rsp_corner_hit)
      else $error("miss with nonzero fields");

   // a corner hit allows no slide on either axis
   a_corner_no_slide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corner_hit |-> rsp_hit && rsp_slide_x == '0 && rsp_slide_y == '0)
      else $error("corner hit with slide");

endmodule

bind swept_box_collision_unit sbc_checker #(.COORD_BITS(COORD_BITS)) u_sbc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_hit            (rsp_hit),
   .rsp_allowed_x      (rsp_allowed_x),
   .rsp_allowed_y      (rsp_allowed_y),
   .rsp_contact_length (rsp_contact_length),
   .rsp_slide_x        (rsp_slide_x),
   .rsp_slide_y        (rsp_slide_y),
   .rsp_corner_hit     (rsp_corner_hit)
);
